// ----- rtl/balvg_pkg.sv -----
// ---------------------------------------------------------------------------
// Battery average guard package
// Widths, register indexes, reset values and fixed counts shared by the
// channel interfaces and the guard itself.
// ---------------------------------------------------------------------------
package balvg_pkg;

  localparam int ADC_BITS            = 12;
  localparam int SAMPLES_PER_AVERAGE = 200;
  localparam int LOW_STREAK_LIMIT    = 3;

  localparam int INTERVAL_W = 16;
  localparam int LEVEL_W    = 20;
  localparam int SUM_W      = 20;
  localparam int COUNT_W    = 8;
  localparam int STREAK_W   = 2;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int STEP_W     = $clog2(LEVEL_W + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_INTERVAL = 2'd0,
    REG_SCALE_DIVISOR   = 2'd1,
    REG_WARN_THRESHOLD  = 2'd2,
    REG_OFF_THRESHOLD   = 2'd3
  } reg_index_t;

  localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd10;
  localparam logic [LEVEL_W-1:0]    SCALE_DIVISOR_RST   = 20'd200;
  localparam logic [LEVEL_W-1:0]    WARN_THRESHOLD_RST  = 20'd0;
  localparam logic [LEVEL_W-1:0]    OFF_THRESHOLD_RST   = 20'd0;

endpackage

// ----- rtl/balvg_tick_if.sv -----
// ---------------------------------------------------------------------------
// Tick channel
// One request per millisecond tick, carrying the battery ADC reading.
// ---------------------------------------------------------------------------
interface balvg_tick_if import balvg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ----- rtl/balvg_report_if.sv -----
// ---------------------------------------------------------------------------
// Report channel
// One request per tick: level, warning and shutdown status.
// ---------------------------------------------------------------------------
interface balvg_report_if import balvg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               report_valid;
  logic [LEVEL_W-1:0] battery_level;
  logic               warn;
  logic               shutdown;

  modport source (output valid, output report_valid, output battery_level,
                  output warn, output shutdown, input ready);
  modport sink (input valid, input report_valid, input battery_level,
                input warn, input shutdown, output ready);
endinterface

// ----- rtl/battery_average_low_voltage_guard.sv -----
// ---------------------------------------------------------------------------
// Battery average low-voltage guard
// Sums one ADC sample every sample_interval ticks, divides the sum of 200
// samples by scale_divisor with a bit-serial divider, flags low levels and
// latches shutdown after three low reports in a row.
// ---------------------------------------------------------------------------
//   channel   | dir | payload                                    | per request
//   tick      | in  | adc_sample                                 | one tick
//   report    | out | report_valid, battery_level, warn, shutdown| one per tick
//   cfg_*     | in  | cfg_index, cfg_data                        | one register
//
// A tick that completes no average has its report loaded into the output
// register at the accepting edge. The tick that completes an average goes
// through the restoring divider, which shifts out one quotient bit per cycle
// until the quotient is done; then S_FIN updates level, warning and streak.
// A tick is accepted only while the output register is empty or being taken.
// Reset is synchronous and clears state and registers, except rem and quo.
// ---------------------------------------------------------------------------
module battery_average_low_voltage_guard import balvg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  balvg_tick_if.sink             tick,
  balvg_report_if.source         report
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t                 state;
  logic [INTERVAL_W-1:0]  sample_interval;
  logic [LEVEL_W-1:0]     scale_divisor;
  logic [LEVEL_W-1:0]     warn_threshold;
  logic [LEVEL_W-1:0]     off_threshold;

  logic [INTERVAL_W-1:0]  elapsed_ticks;
  logic [SUM_W-1:0]       sample_sum;
  logic [COUNT_W-1:0]     sample_count;
  logic [STREAK_W-1:0]    low_streak;
  logic [LEVEL_W-1:0]     last_level;
  logic                   warn_flag;
  logic                   shutdown_latch;

  logic                   out_valid;
  logic                   out_report_valid;

  // Divider: quo starts as the dividend and fills with quotient bits.
  logic [LEVEL_W-1:0]     rem;
  logic [LEVEL_W-1:0]     quo;
  logic [STEP_W-1:0]      step;

  logic                   tick_accept;
  logic [INTERVAL_W-1:0]  elapsed_inc;
  logic                   take_sample;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [COUNT_W-1:0]     count_inc;
  logic                   report_due;
  logic [LEVEL_W:0]       rem_shift;
  logic [LEVEL_W:0]       rem_diff;
  logic                   fits;
  logic [STREAK_W-1:0]    streak_next;
  logic                   out_load;

  assign tick.ready = (state == S_IDLE) && (!out_valid || report.ready);
  assign tick_accept = tick.valid && tick.ready;

  assign report.valid         = out_valid;
  assign report.report_valid  = out_report_valid;
  assign report.battery_level = last_level;
  assign report.warn          = warn_flag;
  assign report.shutdown      = shutdown_latch;

  always_comb begin
    elapsed_inc = (elapsed_ticks != '1) ? elapsed_ticks + INTERVAL_W'(1) : elapsed_ticks;
    take_sample = (elapsed_inc >= sample_interval);
    sum_wide    = {1'b0, sample_sum} + (SUM_W + 1)'(tick.adc_sample);
    sum_sat     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    count_inc   = sample_count + COUNT_W'(1);
    report_due  = take_sample && (count_inc == COUNT_W'(SAMPLES_PER_AVERAGE));

    // A new report is loaded on every tick except the one that starts a division.
    out_load = (state == S_FIN) || (tick_accept && (shutdown_latch || !report_due));

    rem_shift = {rem, quo[LEVEL_W-1]};
    rem_diff  = rem_shift - {1'b0, scale_divisor};
    fits      = (rem_shift >= {1'b0, scale_divisor});

    if (quo <= off_threshold) begin
      streak_next = (low_streak < STREAK_W'(LOW_STREAK_LIMIT)) ? low_streak + STREAK_W'(1)
                                                              : low_streak;
    end else begin
      streak_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sample_interval  <= SAMPLE_INTERVAL_RST;
      scale_divisor    <= SCALE_DIVISOR_RST;
      warn_threshold   <= WARN_THRESHOLD_RST;
      off_threshold    <= OFF_THRESHOLD_RST;
      elapsed_ticks    <= '0;
      sample_sum       <= '0;
      sample_count     <= '0;
      low_streak       <= '0;
      last_level       <= '0;
      warn_flag        <= 1'b0;
      shutdown_latch   <= 1'b0;
      out_valid        <= 1'b0;
      out_report_valid <= 1'b0;
      step             <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[INTERVAL_W-1:0];
          REG_SCALE_DIVISOR:   scale_divisor   <= cfg_data[LEVEL_W-1:0];
          REG_WARN_THRESHOLD:  warn_threshold  <= cfg_data[LEVEL_W-1:0];
          REG_OFF_THRESHOLD:   off_threshold   <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (report.valid && report.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (tick_accept) begin
            if (shutdown_latch) begin
              out_report_valid <= 1'b0;
            end else if (!take_sample) begin
              elapsed_ticks    <= elapsed_inc;
              out_report_valid <= 1'b0;
            end else if (!report_due) begin
              elapsed_ticks    <= '0;
              sample_sum       <= sum_sat;
              sample_count     <= count_inc;
              out_report_valid <= 1'b0;
            end else begin
              // The completing sample goes straight into the divider.
              elapsed_ticks <= '0;
              sample_sum    <= '0;
              sample_count  <= '0;
              rem           <= '0;
              quo           <= sum_sat;
              step          <= '0;
              state         <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem  <= fits ? rem_diff[LEVEL_W-1:0] : rem_shift[LEVEL_W-1:0];
          quo  <= {quo[LEVEL_W-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(LEVEL_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          last_level       <= quo;
          warn_flag        <= (quo < warn_threshold);
          low_streak       <= streak_next;
          if (streak_next >= STREAK_W'(LOW_STREAK_LIMIT)) begin
            shutdown_latch <= 1'b1;
          end
          out_report_valid <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
